// File: hw/rtl/sbc_pkg.sv
// shared types, constants and round functions for the serpent cipher unit
package sbc_pkg;

   localparam int unsigned ROUNDS_DEF = 32;
   localparam int unsigned KEY_REGS = 4;
   localparam logic [31:0] PHI = 32'h9e3779b9;

   typedef struct packed {
      logic        kind;
      logic [63:0] block_lo;
      logic [63:0] block_hi;
   } req_type;

   typedef struct packed {
      logic [63:0] result_lo;
      logic [63:0] result_hi;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_KEYIN,
      ST_ROUND,
      ST_DONE
   } state_type;

   localparam logic KIND_ENC = 1'b0;
   localparam logic KIND_DEC = 1'b1;

   typedef logic [3:0] sbox_row_type [16];
   typedef sbox_row_type sbox_all_type [8];

   localparam sbox_all_type SBOX = '{
      '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
        4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
      '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
        4'd1, 4'd11, 4'd14, 4'd8, 4'd13, 4'd4, 4'd6, 4'd3},
      '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
        4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
      '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
        4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
      '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
        4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
      '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
        4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
      '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
        4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
      '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
        4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
   };

   function automatic logic [3:0] sbox_inv(input logic [2:0] box, input logic [3:0] v);
      logic [3:0] r;
      r = 4'd0;
      for (int k = 0; k < 16; k++) begin
         if (SBOX[box][k] == v) r = 4'(k);
      end
      return r;
   endfunction

   // x packed as word3..word0
   function automatic logic [127:0] sub_cols(input logic [2:0] box, input logic [127:0] x,
                                             input logic inv);
      logic [127:0] y;
      logic [3:0]   v;
      logic [3:0]   o;
      y = '0;
      for (int i = 0; i < 32; i++) begin
         v = {x[96+i], x[64+i], x[32+i], x[i]};
         o = inv ? sbox_inv(box, v) : SBOX[box][v];
         y[i] = o[0];
         y[32+i] = o[1];
         y[64+i] = o[2];
         y[96+i] = o[3];
      end
      return y;
   endfunction

   function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [127:0] lin_fwd(input logic [127:0] v);
      logic [31:0] x0, x1, x2, x3;
      x0 = v[31:0];
      x1 = v[63:32];
      x2 = v[95:64];
      x3 = v[127:96];
      x0 = rol(x0, 13);
      x2 = rol(x2, 3);
      x1 = x1 ^ x0 ^ x2;
      x3 = x3 ^ x2 ^ (x0 << 3);
      x1 = rol(x1, 1);
      x3 = rol(x3, 7);
      x0 = x0 ^ x1 ^ x3;
      x2 = x2 ^ x3 ^ (x1 << 7);
      x0 = rol(x0, 5);
      x2 = rol(x2, 22);
      return {x3, x2, x1, x0};
   endfunction

   function automatic logic [127:0] lin_inv(input logic [127:0] v);
      logic [31:0] x0, x1, x2, x3;
      x0 = v[31:0];
      x1 = v[63:32];
      x2 = v[95:64];
      x3 = v[127:96];
      x2 = rol(x2, 10);
      x0 = rol(x0, 27);
      x2 = x2 ^ x3 ^ (x1 << 7);
      x0 = x0 ^ x1 ^ x3;
      x3 = rol(x3, 25);
      x1 = rol(x1, 31);
      x3 = x3 ^ x2 ^ (x0 << 3);
      x1 = x1 ^ x0 ^ x2;
      x2 = rol(x2, 29);
      x0 = rol(x0, 19);
      return {x3, x2, x1, x0};
   endfunction

endpackage

// File: hw/rtl/sbc_key_sched.sv
// round key expansion and round key memory
module sbc_key_sched
   import sbc_pkg::*;
#(
   parameter int unsigned ROUNDS = ROUNDS_DEF,
   localparam int unsigned NKEYS = ROUNDS + 1,
   localparam int unsigned KW = $clog2(NKEYS)
) (
   input  logic           clock,
   input  logic           start,
   input  logic [255:0]   key,
   input  logic           rd_en,
   input  logic [KW-1:0]  rd_addr,
   output logic [127:0]   rd_data,
   output logic           busy
);

   logic [127:0] mem [NKEYS];
   logic [255:0] win_ff, win_in;
   logic [KW-1:0] k_ff;
   logic [7:0]   n_ff;
   logic         busy_ff;
   logic [127:0] grp;
   logic [2:0]   box;

   // four prekey steps, one round key a cycle
   always_comb begin
      logic [31:0] t;
      win_in = win_ff;
      grp = '0;
      for (int i = 0; i < 4; i++) begin
         t = win_in[31:0] ^ win_in[127:96] ^ win_in[191:160] ^ win_in[255:224] ^ PHI
             ^ {24'd0, n_ff + 8'(i)};
         t = rol(t, 11);
         win_in = {t, win_in[255:32]};
         grp[32*i +: 32] = t;
      end
      box = 3'd3 - k_ff[2:0];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         win_ff <= key;
         k_ff <= '0;
         n_ff <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         mem[k_ff] <= sub_cols(box, grp, 1'b0);
         win_ff <= win_in;
         n_ff <= n_ff + 8'd4;
         k_ff <= k_ff + 1'b1;
         if (k_ff == KW'(NKEYS - 1)) busy_ff <= 1'b0;
      end
      if (rd_en) rd_data <= mem[rd_addr];
   end

   assign busy = busy_ff;

endmodule

// File: hw/rtl/serpent_block_cipher_unit.sv
// serpent block cipher top level with shared round unit
// key write: expansion writes all ROUNDS+1 round keys; a write made while idle holds requests off until expansion ends
// block: the request reads the first round key, ST_KEYIN adds it, then one round a cycle until ST_DONE
// one block in flight; the next request can be taken the cycle after the response is accepted
// reset clears control state; round keys stay undefined until a key write
module serpent_block_cipher_unit
   import sbc_pkg::*;
#(
   parameter int unsigned ROUNDS = ROUNDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int unsigned KW = $clog2(ROUNDS + 1);

   state_type state_ff, state_in;
   logic [63:0]  key_ff [KEY_REGS];
   logic         start_ff;
   logic         kbusy;
   logic [127:0] x_ff, x_in, rk;
   logic [KW-1:0] r_ff, r_in, addr;
   logic         kind_ff;
   logic         rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REGS; i++) key_ff[i] <= '0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= csr_we;
         if (csr_we) key_ff[csr_index] <= csr_wdata;
      end
   end

   sbc_key_sched #(.ROUNDS(ROUNDS)) u_keys (
      .clock(clock), .start(start_ff),
      .key({key_ff[3], key_ff[2], key_ff[1], key_ff[0]}),
      .rd_en(rd_en), .rd_addr(addr), .rd_data(rk), .busy(kbusy)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start_ff) state_in = ST_EXPAND;
                    else if (req_valid) state_in = ST_KEYIN;
         ST_EXPAND: if (!kbusy && !start_ff) state_in = ST_IDLE;
         ST_KEYIN:  state_in = ST_ROUND;
         ST_ROUND:  if (r_ff == KW'(ROUNDS)) state_in = ST_DONE;
         ST_DONE:   if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // round index r_ff counts rounds; each round ends with the next key addition
   always_comb begin
      logic [KW-1:0] rr;
      logic [127:0]  t;
      req_ready = (state_ff == ST_IDLE) && !start_ff;
      rsp_valid = (state_ff == ST_DONE);
      rd_en = 1'b0;
      addr = '0;
      x_in = x_ff;
      r_in = r_ff;
      rr = '0;
      t = x_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_en = 1'b1;
            addr = (req_data.kind == KIND_DEC) ? KW'(ROUNDS) : '0;
            x_in = {req_data.block_hi, req_data.block_lo};
            r_in = '0;
         end
         ST_KEYIN: begin
            rd_en = 1'b1;
            addr = (kind_ff == KIND_DEC) ? KW'(ROUNDS - 1) : KW'(1);
            x_in = x_ff ^ rk;
            r_in = KW'(1);
         end
         ST_ROUND: begin
            rd_en = 1'b1;
            r_in = r_ff + 1'b1;
            if (kind_ff == KIND_ENC) begin
               rr = r_ff - 1'b1;
               t = sub_cols(rr[2:0], x_ff, 1'b0);
               if (r_ff != KW'(ROUNDS)) t = lin_fwd(t);
               x_in = t ^ rk;
               addr = (r_ff >= KW'(ROUNDS - 1)) ? KW'(ROUNDS) : r_ff + 1'b1;
            end else begin
               rr = KW'(ROUNDS) - r_ff;
               t = (r_ff == KW'(1)) ? x_ff : lin_inv(x_ff);
               x_in = sub_cols(rr[2:0], t, 1'b1) ^ rk;
               addr = KW'(ROUNDS) - r_ff - 1'b1;
               if (r_ff >= KW'(ROUNDS - 1)) addr = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff <= '0;
      end else begin
         state_ff <= state_in;
         r_ff <= r_in;
      end
      if (state_ff == ST_IDLE) kind_ff <= req_data.kind;
      if (state_ff != ST_DONE) x_ff <= x_in;
   end

   assign rsp_data.result_lo = x_ff[63:0];
   assign rsp_data.result_hi = x_ff[127:64];

endmodule

// File: hw/rtl/sbc_checker.sv
// port-level checks for the serpent cipher unit, with bind
module sbc_checker
   import sbc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    csr_we
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   a_req_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("unit not busy after request");

   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request taken during key expansion");

endmodule

bind serpent_block_cipher_unit sbc_checker u_sbc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data), .csr_we(csr_we)
);

// File: bench/testbench.sv
// serpent cipher unit bench: keyed encrypt and decrypt requests checked against a local model
module testbench;
   import sbc_pkg::*;

   localparam int NRK = 33;
   localparam logic [1:0] KEY_IDX_0 = 2'd0;
   localparam logic [1:0] KEY_IDX_1 = 2'd1;
   localparam logic [1:0] KEY_IDX_2 = 2'd2;
   localparam logic [1:0] KEY_IDX_3 = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   int send_idle = 0;
   int recv_idle = 0;
   int failures = 0;

   serpent_block_cipher_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // serpent model with its own key schedule and queue of pending expected results
   class cipher_board;
      logic [63:0]  keys [4];
      logic [127:0] rkey [NRK];
      rsp_type      pending [$];

      function logic [3:0] box_fwd(int b, logic [3:0] v);
         logic [3:0] t [8][16];
         t = '{'{3,8,15,1,10,6,5,11,14,13,4,2,7,0,9,12},
               '{15,12,2,7,9,0,5,10,1,11,14,8,13,4,6,3},
               '{8,6,7,9,3,12,10,15,13,1,14,4,0,11,5,2},
               '{0,15,11,8,12,9,6,3,13,1,2,4,10,7,5,14},
               '{1,15,8,3,12,0,11,6,2,5,4,10,9,14,7,13},
               '{15,5,2,11,4,10,9,12,0,3,14,8,13,6,7,1},
               '{7,2,12,5,8,4,6,11,14,9,1,15,13,3,10,0},
               '{1,13,15,0,14,8,2,11,7,4,12,10,9,3,5,6}};
         return t[b][v];
      endfunction

      function logic [127:0] columns(int b, logic [127:0] x, bit inv);
         logic [127:0] y;
         logic [3:0] v, o;
         y = '0;
         for (int i = 0; i < 32; i++) begin
            v = {x[96+i], x[64+i], x[32+i], x[i]};
            o = 4'd0;
            if (inv) begin
               for (int k = 0; k < 16; k++) if (box_fwd(b, 4'(k)) == v) o = 4'(k);
            end else begin
               o = box_fwd(b, v);
            end
            y[i] = o[0]; y[32+i] = o[1]; y[64+i] = o[2]; y[96+i] = o[3];
         end
         return y;
      endfunction

      function logic [31:0] rl(logic [31:0] x, int n);
         return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
      endfunction

      function logic [127:0] mix_fwd(logic [127:0] v);
         logic [31:0] a, b, c, d;
         {d, c, b, a} = v;
         a = rl(a, 13); c = rl(c, 3);
         b = b ^ a ^ c; d = d ^ c ^ (a << 3);
         b = rl(b, 1); d = rl(d, 7);
         a = a ^ b ^ d; c = c ^ d ^ (b << 7);
         a = rl(a, 5); c = rl(c, 22);
         return {d, c, b, a};
      endfunction

      function logic [127:0] mix_inv(logic [127:0] v);
         logic [31:0] a, b, c, d;
         {d, c, b, a} = v;
         c = rl(c, 10); a = rl(a, 27);
         c = c ^ d ^ (b << 7); a = a ^ b ^ d;
         d = rl(d, 25); b = rl(b, 31);
         d = d ^ c ^ (a << 3); b = b ^ a ^ c;
         c = rl(c, 29); a = rl(a, 19);
         return {d, c, b, a};
      endfunction

      function void set_key(int idx, logic [63:0] val);
         logic [31:0] w [8];
         logic [31:0] t;
         logic [127:0] g;
         int n;
         keys[idx] = val;
         for (int i = 0; i < 4; i++) begin
            w[2*i] = keys[i][31:0];
            w[2*i+1] = keys[i][63:32];
         end
         n = 0;
         for (int k = 0; k < NRK; k++) begin
            for (int i = 0; i < 4; i++) begin
               t = rl(w[0] ^ w[3] ^ w[5] ^ w[7] ^ PHI ^ 32'(n), 11);
               for (int j = 0; j < 7; j++) w[j] = w[j+1];
               w[7] = t;
               g[32*i +: 32] = t;
               n++;
            end
            rkey[k] = columns((11 - (k % 8)) % 8, g, 1'b0);
         end
      endfunction

      function void note_request(req_type r);
         logic [127:0] x;
         rsp_type e;
         x = {r.block_hi, r.block_lo};
         if (r.kind == KIND_ENC) begin
            for (int i = 0; i < 32; i++) begin
               x = columns(i % 8, x ^ rkey[i], 1'b0);
               x = (i < 31) ? mix_fwd(x) : (x ^ rkey[32]);
            end
         end else begin
            x = x ^ rkey[32];
            for (int i = 31; i >= 0; i--) begin
               if (i < 31) x = mix_inv(x);
               x = columns(i % 8, x, 1'b1) ^ rkey[i];
            end
         end
         e.result_hi = x[127:64];
         e.result_lo = x[63:0];
         pending = {pending, e};
      endfunction

      function int check_result(rsp_type got);
         rsp_type e;
         int bad;
         bad = 0;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            return 1;
         end
         e = pending.pop_front();
         if (got.result_lo !== e.result_lo) begin
            $error("result_lo expected %h actual %h", e.result_lo, got.result_lo);
            bad = 1;
         end
         if (got.result_hi !== e.result_hi) begin
            $error("result_hi expected %h actual %h", e.result_hi, got.result_hi);
            bad = 1;
         end
         return bad;
      endfunction
   endclass

   cipher_board board = new();

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic bit idle_now(int pct);
      return ($urandom_range(99) < pct);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= !idle_now(recv_idle);
         if (rsp_valid && rsp_ready) failures += board.check_result(rsp_data);
      end
   end

   task automatic write_key(logic [1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_key(idx, val);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // valid stays up after an accept until the next request or an idle gap
   task automatic send_block(logic k, logic [63:0] lo, logic [63:0] hi);
      req_type r;
      r.kind = k; r.block_lo = lo; r.block_hi = hi;
      if (idle_now(send_idle)) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (idle_now(send_idle)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic rekey(int mode);
      logic [63:0] v [4];
      for (int i = 0; i < 4; i++)
         v[i] = (mode == 0) ? 64'd0 : (mode == 1) ? '1 : rnd64();
      write_key(KEY_IDX_0, v[0]);
      write_key(KEY_IDX_1, v[1]);
      write_key(KEY_IDX_2, v[2]);
      write_key(KEY_IDX_3, v[3]);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      rekey(0);
      // directed extremes
      send_block(KIND_ENC, 64'd0, 64'd0);
      send_block(KIND_DEC, 64'd0, 64'd0);
      send_block(KIND_ENC, '1, '1);
      send_block(KIND_DEC, '1, '1);
      drain();
      rekey(1);
      send_block(KIND_ENC, 64'd0, 64'd0);
      send_block(KIND_DEC, '1, '1);
      send_block(KIND_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      send_block(KIND_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      drain();
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_idle = 0; end
            1: begin send_idle = 87; recv_idle = 0; end
            2: begin send_idle = 0; recv_idle = 87; end
            default: begin send_idle = 9; recv_idle = 9; end
         endcase
         if (ph == 5) rekey(0);
         else if (ph == 9) rekey(1);
         else rekey(2);
         // single register change between runs too
         if (ph % 3 == 1) write_key(2'($urandom_range(3)), rnd64());
         for (int n = 0; n < 112; n++)
            send_block(1'($urandom_range(1)), rnd64(), rnd64());
         drain();
      end
      if (failures == 0) begin
         $display("[serpent_block_cipher_unit] OK");
      end else begin
         $display("[serpent_block_cipher_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("[serpent_block_cipher_unit] ERROR");
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_key_sched.sv
hw/rtl/serpent_block_cipher_unit.sv
hw/rtl/sbc_checker.sv
bench/testbench.sv
